FILE: sv/sixaa_pkg.sv
// Shared types and constants for the six-axis accumulate and average block.
// Used by every module in the sv folder; depends on nothing.
package sixaa_pkg;

    localparam int AXIS_COUNT      = 6;
    localparam int SAMPLE_W        = 16;
    localparam int SUM_W           = 32;
    localparam int USED_W          = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int STEP_W          = $clog2(SUM_W);

    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DELIVER
    } ctrl_state_t;

    // Per-beat commands from the controller to every lane.
    typedef struct packed {
        logic acc_en;
        logic start;
        logic step;
    } lane_ctrl_t;

endpackage

FILE: sv/sixaa_lane.sv
// One axis lane: a saturating running sum and a bit-serial restoring divider.
// Depends on sixaa_pkg.
module sixaa_lane #(
    parameter int COUNT_WIDTH = sixaa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sixaa_pkg::lane_ctrl_t               ctrl,
    input  logic signed [sixaa_pkg::SAMPLE_W-1:0] sample,
    input  logic        [COUNT_WIDTH-1:0]       divisor,
    output logic signed [sixaa_pkg::SAMPLE_W-1:0] quotient
);

    localparam int SW = sixaa_pkg::SUM_W;
    localparam int DW = sixaa_pkg::SAMPLE_W;
    localparam logic [SW-1:0] NEG_LIM = SW'(1) << (DW - 1);
    localparam logic [SW-1:0] POS_LIM = NEG_LIM - SW'(1);

    logic signed [SW-1:0]   sum_reg, sum_next;
    logic        [SW-1:0]   div_reg, div_next;
    logic        [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic                   neg_reg, neg_next;

    logic signed [SW:0]     wide_sum;
    logic        [SW-1:0]   magnitude;
    logic        [COUNT_WIDTH:0] shifted;

    assign wide_sum  = $signed({sum_reg[SW-1], sum_reg})
                     + $signed({{(SW + 1 - DW){sample[DW-1]}}, sample});
    assign magnitude = sum_reg[SW-1] ? (~sum_reg + SW'(1)) : sum_reg;
    assign shifted   = {rem_reg, div_reg[SW-1]};

    always_comb
    begin
        sum_next = sum_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (ctrl.acc_en)
        begin
            // Saturate when the extra top bit disagrees with the sign bit.
            if (wide_sum[SW] != wide_sum[SW-1])
            begin
                sum_next = wide_sum[SW] ? {1'b1, {(SW - 1){1'b0}}}
                                        : {1'b0, {(SW - 1){1'b1}}};
            end
            else
            begin
                sum_next = wide_sum[SW-1:0];
            end
        end
        else if (ctrl.start)
        begin
            div_next = magnitude;
            neg_next = sum_reg[SW-1];
            rem_next = '0;
            sum_next = '0;
        end
        else if (ctrl.step)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = COUNT_WIDTH'(shifted - {1'b0, divisor});
                div_next = {div_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[COUNT_WIDTH-1:0];
                div_next = {div_reg[SW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // After the last step div_reg holds the quotient magnitude.
    always_comb
    begin
        if (neg_reg)
        begin
            quotient = (div_reg > NEG_LIM) ? {1'b1, {(DW - 1){1'b0}}}
                                           : -$signed(div_reg[DW-1:0]);
        end
        else
        begin
            quotient = (div_reg > POS_LIM) ? {1'b0, {(DW - 1){1'b1}}}
                                           : $signed(div_reg[DW-1:0]);
        end
    end

endmodule

FILE: sv/sixaa_merge.sv
// Merging stage: gathers the six lane quotients and the flags into the output register.
// Depends on sixaa_pkg.
module sixaa_merge (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              load,
    input  logic [sixaa_pkg::AXIS_COUNT-1:0][sixaa_pkg::SAMPLE_W-1:0] lane_q,
    input  logic                                              empty,
    input  logic [sixaa_pkg::USED_W-1:0]                      used,
    output logic                                              free,
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    // avg_accel_x, avg_accel_y, avg_accel_z, avg_gyro_x, avg_gyro_y, avg_gyro_z, samples_used
    output logic [111:0]                                      m_tdata,
    // no_samples
    output logic [0:0]                                        m_tuser
);

    localparam int AXW = sixaa_pkg::AXIS_COUNT * sixaa_pkg::SAMPLE_W;

    logic             valid_reg, valid_next;
    logic [111:0]     data_reg;
    logic             flag_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            // An empty read reports zero averages.
            data_reg <= {used, empty ? AXW'(0) : AXW'(lane_q)};
            flag_reg <= empty;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = flag_reg;

endmodule

FILE: sv/six_axis_accumulate_average.sv
// Top level of the six-axis accumulate and average block: controller and lane array.
// Depends on sixaa_pkg, sixaa_lane and sixaa_merge.
//
// A sample beat (tuser = 0) adds its six axes to saturating 32-bit sums; once the count
// reaches 2^COUNT_WIDTH - 1 further samples are dropped. A read beat (tuser = 1) produces
// one result beat and clears the sums and the count. The six lanes each divide their sum by
// the count in a restoring divider that yields one quotient bit per cycle, so a read with
// samples occupies the input for its accepting cycle, 32 divide steps and the load into the
// output register, with s_tready low from the first divide step through the load, longer if
// the output register is still waiting for its beat to be taken. A read with no samples
// skips the divide and returns zero averages with tuser set. Sample beats are taken while
// an earlier result waits at the output.
module six_axis_accumulate_average #(
    parameter int COUNT_WIDTH = sixaa_pkg::COUNT_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [95:0]  s_tdata,
    // mode
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // avg_accel_x, avg_accel_y, avg_accel_z, avg_gyro_x, avg_gyro_y, avg_gyro_z, samples_used
    output logic [111:0] m_tdata,
    // no_samples
    output logic [0:0]   m_tuser
);

    localparam int NA  = sixaa_pkg::AXIS_COUNT;
    localparam int DW  = sixaa_pkg::SAMPLE_W;
    localparam int UW  = sixaa_pkg::USED_W;
    localparam int STW = sixaa_pkg::STEP_W;
    localparam int EW  = (COUNT_WIDTH > UW) ? COUNT_WIDTH : UW;
    localparam logic [STW-1:0] LAST_STEP = STW'(sixaa_pkg::SUM_W - 1);

    sixaa_pkg::ctrl_state_t state_reg, state_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] divisor_reg, divisor_next;
    logic [STW-1:0]         step_reg, step_next;
    logic                   empty_reg, empty_next;

    sixaa_pkg::lane_ctrl_t  lane_ctrl;
    logic                   merge_free;
    logic                   merge_load;
    logic [EW-1:0]          divisor_ext;
    logic [UW-1:0]          used;
    logic [NA-1:0][DW-1:0]  lane_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sixaa_pkg::ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        empty_reg   <= empty_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        divisor_next     = divisor_reg;
        step_next        = step_reg;
        empty_next       = empty_reg;
        s_tready         = 1'b0;
        lane_ctrl.acc_en = 1'b0;
        lane_ctrl.start  = 1'b0;
        lane_ctrl.step   = 1'b0;
        merge_load       = 1'b0;
        unique case (state_reg)
            sixaa_pkg::ST_IDLE:
            begin
                // The input is always ready here, so tvalid alone marks a taken beat.
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser[0] == sixaa_pkg::MODE_ACCUM)
                    begin
                        if (count_reg != {COUNT_WIDTH{1'b1}})
                        begin
                            lane_ctrl.acc_en = 1'b1;
                            count_next       = count_reg + COUNT_WIDTH'(1);
                        end
                    end
                    else
                    begin
                        divisor_next = count_reg;
                        count_next   = '0;
                        empty_next   = (count_reg == '0);
                        step_next    = '0;
                        lane_ctrl.start = 1'b1;
                        state_next = (count_reg == '0) ? sixaa_pkg::ST_DELIVER
                                                       : sixaa_pkg::ST_DIVIDE;
                    end
                end
            end
            sixaa_pkg::ST_DIVIDE:
            begin
                lane_ctrl.step = 1'b1;
                step_next      = step_reg + STW'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = sixaa_pkg::ST_DELIVER;
                end
            end
            sixaa_pkg::ST_DELIVER:
            begin
                if (merge_free)
                begin
                    merge_load = 1'b1;
                    state_next = sixaa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sixaa_pkg::ST_IDLE;
            end
        endcase
    end

    // Counts beyond 16 bits report as all ones.
    assign divisor_ext = EW'(divisor_reg);
    assign used = (divisor_ext > EW'({UW{1'b1}})) ? {UW{1'b1}} : divisor_ext[UW-1:0];

    for (genvar g = 0; g < NA; g++)
    begin : g_lane
        sixaa_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .sample   ($signed(s_tdata[g*DW +: DW])),
            .divisor  (divisor_reg),
            .quotient (lane_q[g])
        );
    end

    sixaa_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (merge_load),
        .lane_q   (lane_q),
        .empty    (empty_reg),
        .used     (used),
        .free     (merge_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for six_axis_accumulate_average: sends sample and read beats,
// predicts each average result on its own and compares it field by field with the output.
// Depends on sixaa_pkg and the six_axis_accumulate_average RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W = sixaa_pkg::COUNT_WIDTH_DEF;
    localparam int NAX = sixaa_pkg::AXIS_COUNT;
    localparam int SW = sixaa_pkg::SAMPLE_W;
    localparam longint unsigned COUNT_FULL = (64'd1 << CNT_W) - 1;
    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 60;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [111:0] data;
        logic         no_samples;
    } avg_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic [0:0]   s_tuser = sixaa_pkg::MODE_ACCUM;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [0:0]   m_tuser;

    // Predictor state: six saturating sums and the sample count.
    longint          axis_total[NAX];
    longint unsigned samples_held;
    avg_result_t     pending_averages[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int unexpected_count = 0;
    int beats_sent = 0;
    int reads_sent = 0;
    int results_checked = 0;

    string field_names[8] = '{"avg_accel_x", "avg_accel_y", "avg_accel_z", "avg_gyro_x",
                              "avg_gyro_y", "avg_gyro_z", "samples_used", "no_samples"};

    six_axis_accumulate_average #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_averages.size());
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void clear_averager();
        for (int i = 0; i < NAX; i++)
            axis_total[i] = 0;
        samples_held = 0;
    endfunction

    // Applies one accepted beat to the predictor; a read queues the result it must produce.
    function automatic void accumulate_beat(logic mode, logic [95:0] data);
        longint      v;
        longint      q;
        avg_result_t r;
        if (mode == sixaa_pkg::MODE_ACCUM)
        begin
            if (samples_held >= COUNT_FULL)
                return;
            for (int i = 0; i < NAX; i++)
            begin
                v = $signed(data[SW*i +: SW]);
                v = axis_total[i] + v;
                if (v > SUM_MAX)
                    v = SUM_MAX;
                if (v < SUM_MIN)
                    v = SUM_MIN;
                axis_total[i] = v;
            end
            samples_held++;
            return;
        end
        r.data = '0;
        r.no_samples = (samples_held == 0);
        if (samples_held != 0)
        begin
            for (int i = 0; i < NAX; i++)
            begin
                q = axis_total[i] / longint'(samples_held);
                if (q > 32767)
                    q = 32767;
                if (q < -32768)
                    q = -32768;
                r.data[SW*i +: SW] = q[15:0];
            end
            r.data[111:96] = (samples_held > 65535) ? 16'hFFFF : samples_held[15:0];
        end
        pending_averages.push_back(r);
        clear_averager();
    endfunction

    task automatic note_mismatch(string field, logic [15:0] want, logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("Mismatch on result %0d, %s: expected 0x%04h, got 0x%04h",
                     results_checked, field, want, got);
    endtask

    // Result checker: each output beat is compared with the oldest prediction.
    always @(posedge clk)
    begin
        avg_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_averages.size() == 0)
            begin
                unexpected_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("Unexpected result beat: tdata 0x%028h, tuser %0b",
                             m_tdata, m_tuser);
            end
            else
            begin
                want = pending_averages.pop_front();
                for (int f = 0; f < 7; f++)
                    if (m_tdata[16*f +: 16] !== want.data[16*f +: 16])
                        note_mismatch(field_names[f], want.data[16*f +: 16],
                                      m_tdata[16*f +: 16]);
                if (m_tuser[0] !== want.no_samples)
                    note_mismatch(field_names[7], 16'(want.no_samples), 16'(m_tuser[0]));
                results_checked++;
            end
        end
    end

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'(signed'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [95:0] pick_sample();
        logic [95:0] d;
        for (int i = 0; i < NAX; i++)
            d[SW*i +: SW] = pick_axis();
        return d;
    endfunction

    function automatic logic [95:0] pack_axes(int ax, int ay, int az, int gx, int gy, int gz);
        return {16'(gz), 16'(gy), 16'(gx), 16'(az), 16'(ay), 16'(ax)};
    endfunction

    task automatic send_beat(logic mode, logic [95:0] data);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        accumulate_beat(mode, data);
        beats_sent++;
        if (mode == sixaa_pkg::MODE_READ)
            reads_sent++;
    endtask

    // Stops offering beats and waits until every predicted result has been taken.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        // Reads with nothing accumulated, the second straight after the first.
        send_beat(sixaa_pkg::MODE_READ, pick_sample());
        send_beat(sixaa_pkg::MODE_READ, pick_sample());
        send_beat(sixaa_pkg::MODE_ACCUM, pack_axes(32767, 32767, 32767, 32767, 32767, 32767));
        send_beat(sixaa_pkg::MODE_READ, '0);
        send_beat(sixaa_pkg::MODE_ACCUM,
                  pack_axes(-32768, -32768, -32768, -32768, -32768, -32768));
        send_beat(sixaa_pkg::MODE_ACCUM,
                  pack_axes(-32768, -32768, -32768, -32768, -32768, -32768));
        send_beat(sixaa_pkg::MODE_READ, '1);
        // Odd sums on both sides of zero check truncation toward zero.
        send_beat(sixaa_pkg::MODE_ACCUM, pack_axes(-1, -2, 1, 3, -32768, 32767));
        send_beat(sixaa_pkg::MODE_ACCUM, pack_axes(-2, -2, 2, 4, -1, 0));
        send_beat(sixaa_pkg::MODE_READ, pack_axes(5, 5, 5, 5, 5, 5));
        send_beat(sixaa_pkg::MODE_ACCUM, pack_axes(32767, -32768, 1, -1, 0, 32767));
        send_beat(sixaa_pkg::MODE_ACCUM, pack_axes(-32768, 32767, -1, 1, 0, -32768));
        send_beat(sixaa_pkg::MODE_ACCUM, pack_axes(1, 1, 0, -7, 0, 2));
        send_beat(sixaa_pkg::MODE_READ, 96'hA5A5);
        send_beat(sixaa_pkg::MODE_ACCUM, {6{16'hAAAA}});
        send_beat(sixaa_pkg::MODE_ACCUM, {6{16'h5555}});
        send_beat(sixaa_pkg::MODE_ACCUM, {6{16'h5555}});
        send_beat(sixaa_pkg::MODE_READ, {6{16'h5555}});
        send_beat(sixaa_pkg::MODE_READ, '0);
        wait_for_results();
    endtask

    // Bursts of samples closed by a read, mostly short, now and then long.
    task automatic test_random_traffic(int n_items, int idle, int stall);
        int sent;
        int burst;
        idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items)
        begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
            for (int i = 0; i < burst; i++)
                send_beat(sixaa_pkg::MODE_ACCUM, pick_sample());
            send_beat(sixaa_pkg::MODE_READ, pick_sample());
            sent += burst + 1;
        end
        wait_for_results();
    endtask

    // The receiver holds off while reads and samples keep coming, so the input stalls.
    task automatic test_output_hold();
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 400;
        send_beat(sixaa_pkg::MODE_READ, pick_sample());
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 5; i++)
                send_beat(sixaa_pkg::MODE_ACCUM, pick_sample());
            send_beat(sixaa_pkg::MODE_READ, pick_sample());
        end
        for (int i = 0; i < 4; i++)
            send_beat(sixaa_pkg::MODE_ACCUM, pick_sample());
        send_beat(sixaa_pkg::MODE_READ, pick_sample());
        wait_for_results();
    endtask

    // The sender stops between reads until each result is out, then goes on.
    task automatic test_paced_reads();
        idle_pct = 30;
        stall_pct = 30;
        for (int r = 0; r < 4; r++)
        begin
            for (int i = 0; i < r * 3; i++)
                send_beat(sixaa_pkg::MODE_ACCUM, pick_sample());
            send_beat(sixaa_pkg::MODE_READ, pick_sample());
            wait_for_results();
        end
    endtask

    initial
    begin
        int failures;
        clear_averager();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(180, 0, 0);
        test_random_traffic(180, 61, 0);
        test_output_hold();
        test_random_traffic(180, 0, 61);
        test_paced_reads();
        test_random_traffic(130, 14, 14);

        s_tvalid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        failures = mismatch_count + pending_averages.size();
        $display("Sent %0d beats (%0d reads) over %0d cycles; checked %0d average results,",
                 beats_sent, reads_sent, cycle_count, results_checked);
        $display("covering empty reads, truncation, extreme samples, stalls and a long hold-off.");
        if (pending_averages.size() != 0)
            $display("%0d results never arrived", pending_averages.size());
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
